// ----- hw/rtl/ttp_pkg.sv -----
// Shared types and constant-multiply helpers for the time tag parser.
package ttp_pkg;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;

    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam int VALUE_W  = 64;
    localparam int MILLIS_W = 10;

    typedef struct packed {
        logic       kind;
        logic [7:0] char_code;
    } item_t;

    typedef struct packed {
        logic               ok;
        logic               as_samples;
        logic [VALUE_W-1:0] result_value;
    } result_t;

    // State of one finished tag, handed from the scanner to the finish pipeline
    typedef struct packed {
        logic                failed;
        logic                samples;
        logic                use_p2;
        logic [VALUE_W-1:0]  total;
        logic [VALUE_W-1:0]  p2;
        logic [MILLIS_W-1:0] ms;
    } snap_t;

    typedef struct packed {
        logic                failed;
        logic                samples;
        logic [VALUE_W-1:0]  total;
        logic [MILLIS_W-1:0] ms;
    } mid_t;

    // acc*10 + d; MSB of the result flags 64-bit overflow
    function automatic logic [VALUE_W:0] mac10(input logic [VALUE_W-1:0] acc,
                                               input logic [3:0] d);
        logic [VALUE_W+3:0] w;
        w = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {{VALUE_W{1'b0}}, d};
        return {|w[VALUE_W+3:VALUE_W], w[VALUE_W-1:0]};
    endfunction

    // t*60 + a; MSB flags overflow
    function automatic logic [VALUE_W:0] mac60(input logic [VALUE_W-1:0] t,
                                               input logic [VALUE_W-1:0] a);
        logic [VALUE_W+6:0] w;
        w = ({7'd0, t} << 6) - ({7'd0, t} << 2) + {7'd0, a};
        return {|w[VALUE_W+6:VALUE_W], w[VALUE_W-1:0]};
    endfunction

    // t*1000 + ms; MSB flags overflow
    function automatic logic [VALUE_W:0] mac1000(input logic [VALUE_W-1:0] t,
                                                 input logic [MILLIS_W-1:0] ms);
        logic [VALUE_W+9:0] w;
        w = ({10'd0, t} << 10) - ({10'd0, t} << 4) - ({10'd0, t} << 3)
            + {{VALUE_W{1'b0}}, ms};
        return {|w[VALUE_W+9:VALUE_W], w[VALUE_W-1:0]};
    endfunction

endpackage

// ----- hw/rtl/time_tag_parser.sv -----
// Time tag parser top level: scanner, finish pipeline and limit register.
//
//  channel  direction  handshake                   payload
//  item     in         item_valid / item_ready     item   (kind, char_code)
//  result   out        result_valid / result_ready result (ok, as_samples, result_value)
//  cfg      in         cfg_valid / cfg_ready       cfg_data (limit_to_32_bits)
//
// One item per cycle while item_ready is high. A character updates the scanner registers at
// its transfer; an end item loads the first of three finish registers at its transfer edge,
// then the tag passes the seconds fold and x1000 stages; the hours fold is in the scanner.
// Reset clears scanner, valid flags, limit register. A stalled result backs up the pipeline;
// item_ready drops only when all three stages hold a tag. cfg_ready stays high.
module time_tag_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  ttp_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_ready,
    output ttp_pkg::result_t result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic             cfg_data
);

    logic           limit_reg;
    logic           accept;
    logic           snap_ready;
    ttp_pkg::snap_t snap;

    assign cfg_ready = 1'b1;
    assign accept    = item_valid && item_ready;
    assign item_ready = snap_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= 1'b0;
        else if (cfg_valid && cfg_ready)
            limit_reg <= cfg_data;
    end

    ttp_scan u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .snap   (snap)
    );

    ttp_finish u_finish (
        .clk          (clk),
        .rst_n        (rst_n),
        .snap_valid   (accept && (item.kind == ttp_pkg::KIND_END)),
        .snap_ready   (snap_ready),
        .snap         (snap),
        .limit_32     (limit_reg),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

`ifndef SYNTHESIS
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.ok) |-> (result.result_value == '0 && !result.as_samples))
        else $error("rejected result carries a value");

    a_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.ok && limit_reg) |-> (result.result_value[63:32] == '0))
        else $error("result above 32-bit limit passed");

    a_stall_only_on_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> (result_valid && !result_ready))
        else $error("input stalled without output backpressure");
`endif

endmodule

// ----- hw/rtl/ttp_scan.sv -----
// Character scanner: accumulates tag parts and hands a snapshot on the end item.
module ttp_scan (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  ttp_pkg::item_t item,
    output ttp_pkg::snap_t snap
);

    logic [ttp_pkg::VALUE_W-1:0]  p0_reg, p1_reg, p2_reg;
    logic [ttp_pkg::VALUE_W-1:0]  p0_next, p1_next, p2_next;
    logic [1:0]                   part_index_reg, part_index_next;
    logic [ttp_pkg::MILLIS_W-1:0] millis_reg, millis_next;
    logic [1:0]                   frac_digits_reg, frac_digits_next;
    logic                         seen_colon_reg, seen_colon_next;
    logic                         in_frac_reg, in_frac_next;
    logic                         failed_reg, failed_next;

    logic [ttp_pkg::VALUE_W-1:0]  cur_part;
    logic [ttp_pkg::VALUE_W:0]    part_mac;
    logic [3:0]                   digit;
    logic                         is_digit;
    logic [13:0]                  millis_mac;
    logic [ttp_pkg::VALUE_W:0]    head_mac;

    assign digit    = 4'(item.char_code - ttp_pkg::CHAR_ZERO);
    assign is_digit = (item.char_code >= ttp_pkg::CHAR_ZERO)
                   && (item.char_code <= ttp_pkg::CHAR_NINE);

    always_comb
    begin
        case (part_index_reg)
            2'd0:    cur_part = p0_reg;
            2'd1:    cur_part = p1_reg;
            default: cur_part = p2_reg;
        endcase
    end

    assign part_mac   = ttp_pkg::mac10(cur_part, digit);
    assign millis_mac = 14'(millis_reg) * 14'd10 + 14'(digit);

    always_comb
    begin
        p0_next          = p0_reg;
        p1_next          = p1_reg;
        p2_next          = p2_reg;
        part_index_next  = part_index_reg;
        millis_next      = millis_reg;
        frac_digits_next = frac_digits_reg;
        seen_colon_next  = seen_colon_reg;
        in_frac_next     = in_frac_reg;
        failed_next      = failed_reg;
        if (accept)
        begin
            if (item.kind == ttp_pkg::KIND_END)
            begin
                p0_next          = '0;
                p1_next          = '0;
                p2_next          = '0;
                part_index_next  = '0;
                millis_next      = '0;
                frac_digits_next = '0;
                seen_colon_next  = 1'b0;
                in_frac_next     = 1'b0;
                failed_next      = 1'b0;
            end
            else if (!failed_reg)
            begin
                if (is_digit)
                begin
                    if (in_frac_reg)
                    begin
                        // drop fraction digits past milliseconds
                        if (frac_digits_reg != 2'd3)
                        begin
                            millis_next      = millis_mac[ttp_pkg::MILLIS_W-1:0];
                            frac_digits_next = frac_digits_reg + 2'd1;
                        end
                    end
                    else if (part_mac[ttp_pkg::VALUE_W])
                    begin
                        failed_next = 1'b1;
                    end
                    else
                    begin
                        case (part_index_reg)
                            2'd0:    p0_next = part_mac[ttp_pkg::VALUE_W-1:0];
                            2'd1:    p1_next = part_mac[ttp_pkg::VALUE_W-1:0];
                            default: p2_next = part_mac[ttp_pkg::VALUE_W-1:0];
                        endcase
                    end
                end
                else if (item.char_code == ttp_pkg::CHAR_COLON)
                begin
                    if (in_frac_reg || part_index_reg >= 2'd2)
                        failed_next = 1'b1;
                    else
                    begin
                        seen_colon_next = 1'b1;
                        part_index_next = part_index_reg + 2'd1;
                    end
                end
                else if (item.char_code == ttp_pkg::CHAR_DOT)
                begin
                    if (!seen_colon_reg || in_frac_reg)
                        failed_next = 1'b1;
                    else
                        in_frac_next = 1'b1;
                end
                else
                begin
                    failed_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p0_reg          <= '0;
            p1_reg          <= '0;
            p2_reg          <= '0;
            part_index_reg  <= '0;
            millis_reg      <= '0;
            frac_digits_reg <= '0;
            seen_colon_reg  <= 1'b0;
            in_frac_reg     <= 1'b0;
            failed_reg      <= 1'b0;
        end
        else
        begin
            p0_reg          <= p0_next;
            p1_reg          <= p1_next;
            p2_reg          <= p2_next;
            part_index_reg  <= part_index_next;
            millis_reg      <= millis_next;
            frac_digits_reg <= frac_digits_next;
            seen_colon_reg  <= seen_colon_next;
            in_frac_reg     <= in_frac_next;
            failed_reg      <= failed_next;
        end
    end

    // Fold part 0 into part 1 (x60) here; the finish pipeline does the rest
    assign head_mac = ttp_pkg::mac60(p0_reg, p1_reg);

    always_comb
    begin
        snap.failed  = failed_reg;
        snap.samples = !seen_colon_reg;
        snap.use_p2  = (part_index_reg >= 2'd2);
        snap.p2      = p2_reg;
        if (part_index_reg >= 2'd1)
        begin
            snap.total  = head_mac[ttp_pkg::VALUE_W-1:0];
            snap.failed = failed_reg | head_mac[ttp_pkg::VALUE_W];
        end
        else
            snap.total = p0_reg;
        // pad a short fraction to milliseconds
        case (frac_digits_reg)
            2'd1:    snap.ms = ttp_pkg::MILLIS_W'(millis_reg * 10'd100);
            2'd2:    snap.ms = ttp_pkg::MILLIS_W'(millis_reg * 10'd10);
            default: snap.ms = millis_reg;
        endcase
    end

endmodule

// ----- hw/rtl/ttp_finish.sv -----
// Finish pipeline: last part fold, millisecond scale, limit check, result register.
module ttp_finish (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             snap_valid,
    output logic             snap_ready,
    input  ttp_pkg::snap_t   snap,
    input  logic             limit_32,
    output logic             result_valid,
    input  logic             result_ready,
    output ttp_pkg::result_t result
);

    logic             s1_valid_reg, s2_valid_reg, out_valid_reg;
    ttp_pkg::snap_t   s1_reg;
    ttp_pkg::mid_t    s2_reg, s2_next;
    ttp_pkg::result_t out_reg, out_next;
    logic             out_free, s2_ready;
    logic [ttp_pkg::VALUE_W:0] sec_mac, ms_mac;
    logic [ttp_pkg::VALUE_W-1:0] value;
    logic             bad;

    assign out_free   = !out_valid_reg || result_ready;
    assign s2_ready   = !s2_valid_reg || out_free;
    assign snap_ready = !s1_valid_reg || s2_ready;

    // stage 2: fold in seconds
    assign sec_mac = ttp_pkg::mac60(s1_reg.total, s1_reg.p2);

    always_comb
    begin
        s2_next.samples = s1_reg.samples;
        s2_next.ms      = s1_reg.ms;
        if (s1_reg.use_p2)
        begin
            s2_next.total  = sec_mac[ttp_pkg::VALUE_W-1:0];
            s2_next.failed = s1_reg.failed | sec_mac[ttp_pkg::VALUE_W];
        end
        else
        begin
            s2_next.total  = s1_reg.total;
            s2_next.failed = s1_reg.failed;
        end
    end

    // output stage: scale clock tags to milliseconds and apply the 32-bit limit
    assign ms_mac = ttp_pkg::mac1000(s2_reg.total, s2_reg.ms);

    always_comb
    begin
        if (s2_reg.samples)
        begin
            value = s2_reg.total;
            bad   = s2_reg.failed;
        end
        else
        begin
            value = ms_mac[ttp_pkg::VALUE_W-1:0];
            bad   = s2_reg.failed | ms_mac[ttp_pkg::VALUE_W];
        end
        if (limit_32 && (value[ttp_pkg::VALUE_W-1:32] != '0))
            bad = 1'b1;
        out_next.ok           = !bad;
        out_next.as_samples   = !bad && s2_reg.samples;
        out_next.result_value = bad ? '0 : value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (snap_ready)
                s1_valid_reg <= snap_valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
            if (out_free)
                out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap_ready && snap_valid)
            s1_reg <= snap;
        if (s2_ready && s1_valid_reg)
            s2_reg <= s2_next;
        if (out_free && s2_valid_reg)
            out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

// ----- verif/time_tag_parser_checker.sv -----
// Checker for the time tag parser: tracks tag state from item transfers and checks each result.
module time_tag_parser_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  logic             item_ready,
    input  ttp_pkg::item_t   item,
    input  logic             result_valid,
    input  logic             result_ready,
    input  ttp_pkg::result_t result,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic             cfg_data,
    output int               failures,
    output int               pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] MAX_32 = 64'h0000_0000_FFFF_FFFF;

    logic                         limit_32;
    logic [63:0]                  tag_parts [3];
    logic [1:0]                   part_sel;
    logic [ttp_pkg::MILLIS_W-1:0] frac_val;
    logic [1:0]                   frac_cnt;
    logic                         tag_has_colon;
    logic                         tag_in_frac;
    logic                         tag_bad;
    ttp_pkg::result_t             expected_q [$];

    // a*m + b, bit 64 set when the true value does not fit in 64 bits
    function automatic logic [64:0] times_plus(input logic [63:0] a, input logic [63:0] m,
                                               input logic [63:0] b);
        logic [127:0] w;
        w = {64'd0, a} * {64'd0, m} + {64'd0, b};
        return {|w[127:64], w[63:0]};
    endfunction

    function automatic void clear_tag();
        tag_parts[0]  = '0;
        tag_parts[1]  = '0;
        tag_parts[2]  = '0;
        part_sel      = '0;
        frac_val      = '0;
        frac_cnt      = '0;
        tag_has_colon = 1'b0;
        tag_in_frac   = 1'b0;
        tag_bad       = 1'b0;
    endfunction

    function automatic void scan_char(input logic [7:0] c);
        logic [64:0] w;
        if (!tag_bad)
        begin
            if (c >= ttp_pkg::CHAR_ZERO && c <= ttp_pkg::CHAR_NINE)
            begin
                if (tag_in_frac)
                begin
                    // digits past the third are dropped
                    if (frac_cnt < 2'd3)
                    begin
                        frac_val = frac_val * 10'd10
                                   + ttp_pkg::MILLIS_W'(c - ttp_pkg::CHAR_ZERO);
                        frac_cnt = frac_cnt + 2'd1;
                    end
                end
                else
                begin
                    w = times_plus(tag_parts[part_sel], 64'd10, 64'(c - ttp_pkg::CHAR_ZERO));
                    if (w[64])
                        tag_bad = 1'b1;
                    else
                        tag_parts[part_sel] = w[63:0];
                end
            end
            else if (c == ttp_pkg::CHAR_COLON)
            begin
                if (tag_in_frac || part_sel >= 2'd2)
                begin
                    tag_bad = 1'b1;
                end
                else
                begin
                    tag_has_colon = 1'b1;
                    part_sel      = part_sel + 2'd1;
                end
            end
            else if (c == ttp_pkg::CHAR_DOT)
            begin
                if (!tag_has_colon || tag_in_frac)
                    tag_bad = 1'b1;
                else
                    tag_in_frac = 1'b1;
            end
            else
            begin
                tag_bad = 1'b1;
            end
        end
    endfunction

    function automatic ttp_pkg::result_t close_tag();
        ttp_pkg::result_t r;
        logic [64:0]      w;
        logic [63:0]      tot;
        logic [63:0]      ms;
        logic             good;
        int               k;
        good = !tag_bad;
        tot  = '0;
        ms   = 64'(frac_val);
        if (!tag_has_colon)
        begin
            r.as_samples = 1'b1;
            tot          = tag_parts[0];
        end
        else
        begin
            r.as_samples = 1'b0;
            // pad a short fraction out to milliseconds
            for (k = int'(frac_cnt); k < 3; k++)
                ms = ms * 64'd10;
            for (k = 0; k <= int'(part_sel); k++)
            begin
                w    = times_plus(tot, 64'd60, tag_parts[k]);
                good = good && !w[64];
                tot  = w[63:0];
            end
            w    = times_plus(tot, 64'd1000, ms);
            good = good && !w[64];
            tot  = w[63:0];
        end
        if (good && limit_32 && tot > MAX_32)
            good = 1'b0;
        if (!good)
        begin
            r.as_samples = 1'b0;
            tot          = '0;
        end
        r.ok           = good;
        r.result_value = tot;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        ttp_pkg::result_t exp_r;
        if (!rst_n)
        begin
            clear_tag();
            limit_32 = 1'b0;
            expected_q.delete();
            failures = 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result transfer with nothing expected: ok=%0d samples=%0d value=%0d",
                           result.ok, result.as_samples, result.result_value);
                    failures++;
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    if (result.ok !== exp_r.ok)
                    begin
                        $error("ok: expected %0d, got %0d", exp_r.ok, result.ok);
                        failures++;
                    end
                    if (result.as_samples !== exp_r.as_samples)
                    begin
                        $error("as_samples: expected %0d, got %0d",
                               exp_r.as_samples, result.as_samples);
                        failures++;
                    end
                    if (result.result_value !== exp_r.result_value)
                    begin
                        $error("result_value: expected %0d, got %0d",
                               exp_r.result_value, result.result_value);
                        failures++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                limit_32 = cfg_data;
            if (item_valid && item_ready)
            begin
                if (item.kind == ttp_pkg::KIND_END)
                begin
                    expected_q.push_back(close_tag());
                    clear_tag();
                end
                else
                begin
                    scan_char(item.char_code);
                end
            end
        end
        pending = expected_q.size();
    end

endmodule

// ----- verif/time_tag_parser_tb.sv -----
// Top of the time tag parser testbench: clock, reset, tag stimulus, flow control and verdict.
module time_tag_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STUCK_LIMIT = 4000;
    localparam int HOLD_CYCLES = 80;
    localparam int PIPE_DRAIN  = 6;

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             item_valid   = 1'b0;
    logic             item_ready;
    ttp_pkg::item_t   item         = '0;
    logic             result_valid;
    logic             result_ready = 1'b0;
    ttp_pkg::result_t result;
    logic             cfg_valid    = 1'b0;
    logic             cfg_ready;
    logic             cfg_data     = 1'b0;

    int         fail_count;
    int         expected_left;
    int         idle_mode    = 0;
    logic       hold_req     = 1'b0;
    logic       hold_done;
    int         hold_left;
    int         stuck_cycles = 0;
    int         items_sent   = 0;
    logic [7:0] tag_chars [$];

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    time_tag_parser u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    time_tag_parser_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .failures     (fail_count),
        .pending      (expected_left)
    );

    function automatic bit sender_idles();
        return (idle_mode == 1 && $urandom_range(0, 99) < 86) ||
               (idle_mode == 3 && $urandom_range(0, 99) < 19);
    endfunction

    function automatic bit receiver_stalls();
        return (idle_mode == 2 && $urandom_range(0, 99) < 86) ||
               (idle_mode == 3 && $urandom_range(0, 99) < 19);
    endfunction

    // one long hold-off on request, random stalls otherwise
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            hold_left    <= 0;
            hold_done    <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            result_ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end
        else if (hold_req && !hold_done)
        begin
            result_ready <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            hold_done    <= 1'b1;
        end
        else
        begin
            result_ready <= !receiver_stalls();
        end
    end

    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready) ||
            (cfg_valid && cfg_ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            tag_chars.push_back(s[i]);
    endfunction

    function automatic void push_digits(input int n);
        for (int i = 0; i < n; i++)
            tag_chars.push_back(ttp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
    endfunction

    function automatic void push_number(input longint unsigned v);
        push_text($sformatf("%0d", v));
    endfunction

    // mostly short parts, now and then long enough to overflow
    function automatic void push_part();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return;
        else if (roll <= 6)
            push_digits($urandom_range(1, 2));
        else if (roll <= 8)
            push_digits($urandom_range(3, 5));
        else
            push_digits($urandom_range(15, 20));
    endfunction

    function automatic void build_clock_tag();
        if ($urandom_range(0, 1))
        begin
            push_part();
            tag_chars.push_back(ttp_pkg::CHAR_COLON);
        end
        push_part();
        tag_chars.push_back(ttp_pkg::CHAR_COLON);
        push_part();
        if ($urandom_range(0, 2) != 0)
        begin
            tag_chars.push_back(ttp_pkg::CHAR_DOT);
            push_digits($urandom_range(0, 5));
        end
    endfunction

    task automatic send_item(input ttp_pkg::item_t it);
        while (sender_idles())
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
    endtask

    // send the buffered characters, then the end item
    task automatic send_tag(input bit counted);
        ttp_pkg::item_t it;
        foreach (tag_chars[i])
        begin
            it.kind      = ttp_pkg::KIND_CHAR;
            it.char_code = tag_chars[i];
            send_item(it);
        end
        it.kind      = ttp_pkg::KIND_END;
        it.char_code = 8'($urandom_range(0, 255));
        send_item(it);
        if (counted)
            items_sent += tag_chars.size() + 1;
        tag_chars.delete();
    endtask

    task automatic send_text(input string s);
        push_text(s);
        send_tag(1'b1);
    endtask

    task automatic random_tag();
        int         roll;
        int         pos;
        logic [7:0] junk;
        bit         counted;
        roll    = $urandom_range(0, 99);
        counted = 1'b1;
        if (roll < 35)
        begin
            build_clock_tag();
        end
        else if (roll < 45)
        begin
            // hours around the 32-bit millisecond boundary
            push_number(64'($urandom_range(1100, 1300)));
            tag_chars.push_back(ttp_pkg::CHAR_COLON);
            push_number(64'($urandom_range(0, 59)));
            tag_chars.push_back(ttp_pkg::CHAR_COLON);
            push_number(64'($urandom_range(0, 59)));
            if ($urandom_range(0, 1))
            begin
                tag_chars.push_back(ttp_pkg::CHAR_DOT);
                push_digits($urandom_range(1, 3));
            end
        end
        else if (roll < 60)
        begin
            push_digits($urandom_range(0, 12));
        end
        else if (roll < 70)
        begin
            // sample counts straddling the 32-bit and 64-bit limits
            if ($urandom_range(0, 1))
                push_text("1844674407370955161");
            else
                push_text("429496729");
            push_digits(1);
        end
        else if (roll < 85)
        begin
            build_clock_tag();
            pos = $urandom_range(0, tag_chars.size());
            case ($urandom_range(0, 2))
                0:       junk = ttp_pkg::CHAR_COLON;
                1:       junk = ttp_pkg::CHAR_DOT;
                default: junk = 8'($urandom_range(0, 255));
            endcase
            tag_chars.insert(pos, junk);
        end
        else
        begin
            counted = 1'b0;
            repeat ($urandom_range(0, 8))
            begin
                case ($urandom_range(0, 3))
                    0:       push_digits(1);
                    1:       tag_chars.push_back(ttp_pkg::CHAR_COLON);
                    2:       tag_chars.push_back(ttp_pkg::CHAR_DOT);
                    default: tag_chars.push_back(8'($urandom_range(0, 255)));
                endcase
            end
        end
        send_tag(counted);
    endtask

    // drop valid, wait out every expected result and the finish pipeline
    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (expected_left != 0)
            @(posedge clk);
        repeat (PIPE_DRAIN) @(posedge clk);
    endtask

    task automatic write_limit(input logic v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int goal;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_limit(1'b0);
        send_tag(1'b1);
        tag_chars.push_back(8'h00);
        send_tag(1'b1);
        tag_chars.push_back(8'hFF);
        tag_chars.push_back(ttp_pkg::CHAR_ZERO + 8'd5);
        send_tag(1'b1);
        send_text(".");
        send_text(":..");
        send_text(":::");
        send_text(":.:");
        send_text("9:.1234");
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            write_limit(ph % 2 == 0);
            idle_mode <= ph;
            if (ph == 0)
                hold_req <= 1'b1;
            goal = items_sent + 250;
            while (items_sent < goal)
                random_tag();
            drain();
        end

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
